// File: sv/pll_pkg.sv
// ----------------------------------------------------------------------------
// pll_pkg
// Shared types and constants for the polyline path length block: controller
// states and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package pll_pkg;

   // Width of the running path total, FRAC_BITS fraction bits included.
   localparam int TOTAL_BITS = 48;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_SUM,
      ST_ROOT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load;       // capture the request point and form the differences
      logic square;     // square both differences
      logic sum;        // add the squares and prime the square root
      logic root_step;  // one radix-2 square root iteration
      logic finish;     // update the total and present the result
   } cmd_type;

   typedef struct packed {
      logic path_start; // the offered point begins a new path
      logic out_free;   // the result register can take a value this cycle
   } status_type;

endpackage

// File: sv/pll_ctrl.sv
// ----------------------------------------------------------------------------
// pll_ctrl
// Sequencer for the path length datapath: accepts a point, steps through
// squaring, summing and the bit-serial square root, then hands over the result.
// ----------------------------------------------------------------------------
module pll_ctrl #(
   parameter int ROOT_STEPS = 25
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  pll_pkg::status_type status,
   output pll_pkg::cmd_type    cmd
);

   localparam int CntW = $clog2(ROOT_STEPS);

   pll_pkg::state_type state_ff, state_in;
   logic [CntW-1:0]    cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pll_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         pll_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               // A new path needs no arithmetic: its segment is zero.
               if (status.path_start) begin
                  state_in = pll_pkg::ST_FINISH;
               end else begin
                  state_in = pll_pkg::ST_SQUARE;
               end
            end
         end
         pll_pkg::ST_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = pll_pkg::ST_SUM;
         end
         pll_pkg::ST_SUM: begin
            cmd.sum  = 1'b1;
            cnt_in   = CntW'(ROOT_STEPS - 1);
            state_in = pll_pkg::ST_ROOT;
         end
         pll_pkg::ST_ROOT: begin
            cmd.root_step = 1'b1;
            if (cnt_ff == '0) begin
               state_in = pll_pkg::ST_FINISH;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         pll_pkg::ST_FINISH: begin
            cmd.finish = 1'b1;
            if (status.out_free) begin
               state_in = pll_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pll_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// File: sv/pll_datapath.sv
// ----------------------------------------------------------------------------
// pll_datapath
// Coordinate differences, squaring, radix-2 restoring square root and the
// saturating path total, with the registered result stage.
// ----------------------------------------------------------------------------
module pll_datapath #(
   parameter int COORD_BITS = 16,
   parameter int FRAC_BITS  = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  pll_pkg::cmd_type                cmd,
   output pll_pkg::status_type             status,
   input  logic signed [COORD_BITS-1:0]    req_point_x,
   input  logic signed [COORD_BITS-1:0]    req_point_y,
   input  logic                            req_restart,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [COORD_BITS+FRAC_BITS:0]   rsp_segment_length,
   output logic [pll_pkg::TOTAL_BITS-1:0]  rsp_total_length
);

   localparam int SegW  = COORD_BITS + FRAC_BITS + 1;
   localparam int SqW   = 2 * COORD_BITS;
   localparam int SumW  = 2 * COORD_BITS + 1;
   localparam int RadW  = 2 * SegW;
   localparam int RemW  = SegW + 2;
   localparam int TotW  = pll_pkg::TOTAL_BITS;

   logic signed [COORD_BITS-1:0] prev_x_ff, prev_y_ff;
   logic                         have_prev_ff;
   logic                         start_ff;
   logic [COORD_BITS-1:0]        dx_ff, dy_ff;
   logic [SqW-1:0]               sx_ff, sy_ff;
   logic [RadW-1:0]              rad_ff;
   logic [RemW-1:0]              rem_ff;
   logic [SegW-1:0]              root_ff;
   logic [TotW-1:0]              total_ff;
   logic                         rsp_valid_ff;
   logic [SegW-1:0]              rsp_seg_ff;
   logic [TotW-1:0]              rsp_total_ff;

   logic signed [COORD_BITS:0]   diff_x, diff_y;
   logic [COORD_BITS-1:0]        mag_x, mag_y;
   logic [SumW-1:0]              sq_sum;
   logic [RemW-1:0]              rem_shift, trial;
   logic                         fits;
   logic [TotW:0]                total_sum;
   logic [TotW-1:0]              total_in;
   logic                         path_start;
   logic                         out_free;
   logic                         out_load;

   assign diff_x = {req_point_x[COORD_BITS-1], req_point_x}
                 - {prev_x_ff[COORD_BITS-1], prev_x_ff};
   assign diff_y = {req_point_y[COORD_BITS-1], req_point_y}
                 - {prev_y_ff[COORD_BITS-1], prev_y_ff};
   // A magnitude never exceeds 2^COORD_BITS - 1, so the sign bit can go.
   assign mag_x  = COORD_BITS'(diff_x[COORD_BITS] ? -diff_x : diff_x);
   assign mag_y  = COORD_BITS'(diff_y[COORD_BITS] ? -diff_y : diff_y);

   assign sq_sum = SumW'(sx_ff) + SumW'(sy_ff);

   // Bring down the next two radicand bits and try the next root bit.
   assign rem_shift = {rem_ff[RemW-3:0], rad_ff[RadW-1 -: 2]};
   assign trial     = {root_ff, 2'b01};
   assign fits      = rem_shift >= trial;

   assign total_sum = {1'b0, total_ff} + (TotW + 1)'(root_ff);
   always_comb begin
      if (start_ff) begin
         total_in = '0;
      end else if (total_sum[TotW]) begin
         total_in = '1;
      end else begin
         total_in = total_sum[TotW-1:0];
      end
   end

   assign path_start = req_restart || !have_prev_ff;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign out_load   = cmd.finish && out_free;

   assign status.path_start = path_start;
   assign status.out_free   = out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         have_prev_ff <= 1'b0;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            have_prev_ff <= 1'b1;
            prev_x_ff    <= req_point_x;
            prev_y_ff    <= req_point_y;
         end
         if (out_load) begin
            total_ff     <= total_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         start_ff <= path_start;
         dx_ff    <= mag_x;
         dy_ff    <= mag_y;
         rem_ff   <= '0;
         root_ff  <= '0;
      end
      if (cmd.square) begin
         sx_ff <= SqW'(dx_ff) * SqW'(dx_ff);
         sy_ff <= SqW'(dy_ff) * SqW'(dy_ff);
      end
      if (cmd.sum) begin
         rad_ff <= RadW'(sq_sum) << (2 * FRAC_BITS);
      end
      if (cmd.root_step) begin
         rad_ff <= rad_ff << 2;
         if (fits) begin
            rem_ff  <= rem_shift - trial;
            root_ff <= {root_ff[SegW-2:0], 1'b1};
         end else begin
            rem_ff  <= rem_shift;
            root_ff <= {root_ff[SegW-2:0], 1'b0};
         end
      end
      if (out_load) begin
         rsp_seg_ff   <= root_ff;
         rsp_total_ff <= total_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_segment_length = rsp_seg_ff;
   assign rsp_total_length   = rsp_total_ff;

endmodule

// File: sv/polyline_path_length.sv
// ----------------------------------------------------------------------------
// polyline_path_length
// Euclidean length of a stream of points, per segment and as a running total.
// ----------------------------------------------------------------------------
// Points arrive on the req_ channel (x, y and a restart flag); each accepted
// point yields exactly one transfer on the rsp_ channel carrying the segment
// length from the previous point and the path total so far, both unsigned
// with FRAC_BITS fraction bits. The first point after reset, or a point with
// restart set, opens a new path: its segment length and total are zero.
// The total saturates at its maximum until the next new path.
// A segment passes from acceptance to the result register through a squaring
// step, a summing step and the bit-serial square root, which resolves one
// root bit per cycle, and then a step that updates the total; a new path goes
// straight to that final step. The block works on one point at a time and
// accepts the next one in the cycle after its result has been loaded into
// the output register, even if that result is still waiting. A stalled
// result holds; the block then waits in its final step until the register
// is free. Reset empties the result register and forgets the previous point.
// ----------------------------------------------------------------------------
module polyline_path_length #(
   parameter int COORD_BITS = 16,
   parameter int FRAC_BITS  = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic signed [COORD_BITS-1:0]    req_point_x,
   input  logic signed [COORD_BITS-1:0]    req_point_y,
   input  logic                            req_restart,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [COORD_BITS+FRAC_BITS:0]   rsp_segment_length,
   output logic [pll_pkg::TOTAL_BITS-1:0]  rsp_total_length
);

   pll_pkg::cmd_type    cmd;
   pll_pkg::status_type status;

   pll_ctrl #(
      .ROOT_STEPS (COORD_BITS + FRAC_BITS + 1)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   pll_datapath #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_point_x        (req_point_x),
      .req_point_y        (req_point_y),
      .req_restart        (req_restart),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_segment_length (rsp_segment_length),
      .rsp_total_length   (rsp_total_length)
   );

endmodule
